// ===== hdl/dcpa_pkg.sv =====
// Package for the dual-channel peak average unit: item types, field widths,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package dcpa_pkg;

    localparam int CODE_W     = 12;
    localparam int GAIN_W     = 18;
    localparam int LEN_W      = 8;
    localparam int VOLT_W     = 10;
    localparam int PROD_W     = CODE_W + GAIN_W;
    localparam int VOLT_SHIFT = 20;
    localparam int CFG_W      = GAIN_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 18'd109725;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 8'd128;
    localparam logic [VOLT_W-1:0] VOLT_MAX     = '1;

    localparam int AVG_DEPTH_DEFAULT = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    typedef struct packed {
        logic [CODE_W-1:0] mains_code;
        logic [CODE_W-1:0] pfc_code;
    } sample_t;

    typedef struct packed {
        logic [VOLT_W-1:0] mains_average;
        logic [VOLT_W-1:0] pfc_average;
    } result_t;

    // Floor of log2, evaluated at elaboration for the averaging shift.
    function automatic int floor_log2(input int value);
        int s;
        int v;
        s = 0;
        v = value;
        while (v > 1)
        begin
            v = v >> 1;
            s = s + 1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dcpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies; used for the peak ring storage.
`default_nettype none

module dcpa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/dual_channel_peak_average_unit.sv =====
// Top level of the dual-channel peak average unit: scaling, peak windows,
// ring storage with running sums and the result register.
// Depends on dcpa_pkg and dcpa_ram.
//
//  Port group     Direction  Handshake                  Payload
//  sample         in         sample_valid/sample_ready  sample_t (two ADC codes)
//  result         out        result_valid/result_ready  result_t (two averages)
//  configuration  in         cfg_write                  cfg_index, cfg_data
//
// One item per cycle is accepted; a stalled result holds the pipeline, but an
// empty multiply stage still takes an item during a stall. The item that closes
// a window passes the multiply stage register, then the ring update loads the
// result register. The ring memory is read ahead at the next slot, so closes
// may follow back to back. Reset zeroes the peaks, counters, sums and ring valid
// bits at once; ring entries that were never written read as zero.
`default_nettype none

module dual_channel_peak_average_unit
    import dcpa_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire sample_t              sample,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output result_t                   result,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W     = $clog2(AVG_DEPTH);
    localparam int SUM_W     = VOLT_W + $clog2(AVG_DEPTH);
    localparam int AVG_SHIFT = floor_log2(AVG_DEPTH);
    localparam int RING_W    = 2 * VOLT_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(AVG_DEPTH - 1);

    // Configuration registers.
    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_SCALE_GAIN)
            begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
            else if (cfg_index == REG_WINDOW_LENGTH)
            begin
                length_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    // Flow control.
    logic advance;
    logic s1_valid_reg;
    logic fire;
    logic accept;

    assign advance      = !result_valid || result_ready;
    assign sample_ready = !s1_valid_reg || advance;
    assign accept       = sample_valid && sample_ready;
    assign fire         = s1_valid_reg && advance;

    // Stage 1: scale both codes to volts.
    logic [PROD_W-1:0] mains_prod;
    logic [PROD_W-1:0] pfc_prod;
    logic [VOLT_W-1:0] mains_volt_reg;
    logic [VOLT_W-1:0] pfc_volt_reg;

    assign mains_prod = PROD_W'(sample.mains_code) * PROD_W'(gain_reg);
    assign pfc_prod   = PROD_W'(sample.pfc_code) * PROD_W'(gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mains_volt_reg <= mains_prod[VOLT_SHIFT +: VOLT_W];
            pfc_volt_reg   <= pfc_prod[VOLT_SHIFT +: VOLT_W];
        end
    end

    // Stage 2: peak windows, ring update and running sums.
    logic [LEN_W-1:0]     count_reg,     count_next;
    logic [VOLT_W-1:0]    mains_peak_reg, mains_peak_next;
    logic [VOLT_W-1:0]    pfc_peak_reg,   pfc_peak_next;
    logic [IDX_W-1:0]     pos_reg,       pos_next;
    logic [AVG_DEPTH-1:0] ring_valid_reg, ring_valid_next;
    logic                 rd_valid_reg;
    logic [SUM_W-1:0]     mains_sum_reg, mains_sum_next;
    logic [SUM_W-1:0]     pfc_sum_reg,   pfc_sum_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg,       result_next;

    logic              close;
    logic [RING_W-1:0] ring_rd_data;
    logic [VOLT_W-1:0] mains_old;
    logic [VOLT_W-1:0] pfc_old;
    logic [SUM_W-1:0]  mains_avg_full;
    logic [SUM_W-1:0]  pfc_avg_full;

    assign close = count_reg >= length_reg;

    // The read port always looks at the slot the next close will overwrite.
    assign mains_old = rd_valid_reg ? ring_rd_data[RING_W-1:VOLT_W] : '0;
    assign pfc_old   = rd_valid_reg ? ring_rd_data[VOLT_W-1:0] : '0;

    always_comb
    begin
        count_next        = count_reg;
        mains_peak_next   = mains_peak_reg;
        pfc_peak_next     = pfc_peak_reg;
        pos_next          = pos_reg;
        ring_valid_next   = ring_valid_reg;
        mains_sum_next    = mains_sum_reg;
        pfc_sum_next      = pfc_sum_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        mains_avg_full    = '0;
        pfc_avg_full      = '0;
        if (fire)
        begin
            if (!close)
            begin
                if (mains_volt_reg > mains_peak_reg)
                begin
                    mains_peak_next = mains_volt_reg;
                end
                if (pfc_volt_reg > pfc_peak_reg)
                begin
                    pfc_peak_next = pfc_volt_reg;
                end
                count_next = count_reg + LEN_W'(1);
            end
            else
            begin
                mains_sum_next = mains_sum_reg + SUM_W'(mains_peak_reg) - SUM_W'(mains_old);
                pfc_sum_next   = pfc_sum_reg + SUM_W'(pfc_peak_reg) - SUM_W'(pfc_old);
                ring_valid_next[pos_reg] = 1'b1;
                pos_next        = (pos_reg == LAST_SLOT) ? '0 : pos_reg + IDX_W'(1);
                mains_peak_next = '0;
                pfc_peak_next   = '0;
                count_next      = '0;
                mains_avg_full  = mains_sum_next >> AVG_SHIFT;
                pfc_avg_full    = pfc_sum_next >> AVG_SHIFT;
                // Saturation only matters when the depth is not a power of two.
                result_next.mains_average = (mains_avg_full > SUM_W'(VOLT_MAX)) ?
                                            VOLT_MAX : mains_avg_full[VOLT_W-1:0];
                result_next.pfc_average   = (pfc_avg_full > SUM_W'(VOLT_MAX)) ?
                                            VOLT_MAX : pfc_avg_full[VOLT_W-1:0];
                result_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            mains_peak_reg   <= '0;
            pfc_peak_reg     <= '0;
            pos_reg          <= '0;
            ring_valid_reg   <= '0;
            rd_valid_reg     <= 1'b0;
            mains_sum_reg    <= '0;
            pfc_sum_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            mains_peak_reg   <= mains_peak_next;
            pfc_peak_reg     <= pfc_peak_next;
            pos_reg          <= pos_next;
            ring_valid_reg   <= ring_valid_next;
            rd_valid_reg     <= ring_valid_reg[pos_next];
            mains_sum_reg    <= mains_sum_next;
            pfc_sum_reg      <= pfc_sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    dcpa_ram #(
        .WIDTH (RING_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (fire && close),
        .wr_addr (pos_reg),
        .wr_data ({mains_peak_reg, pfc_peak_reg}),
        .rd_addr (pos_next),
        .rd_data (ring_rd_data)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A close clears the window and always produces a result.
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && close |=> count_reg == '0 && mains_peak_reg == '0 && result_valid_reg)
        else $error("window close did not clear state or produce a result");

    // Peaks never fall inside a window.
    a_peak_rises: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !close |=> mains_peak_reg >= $past(mains_peak_reg)
                           && pfc_peak_reg >= $past(pfc_peak_reg))
        else $error("peak dropped within a window");

    // The ring slot moves only on a close.
    a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && close) |=> $stable(pos_reg))
        else $error("ring slot moved without a close");

    // A pending result is never overwritten while stalled.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |=> $stable(result_reg))
        else $error("stalled result was overwritten");

endmodule

`default_nettype wire
